[rtl/rgbyuv_pkg.sv]
`timescale 1ns / 1ps

package rgbyuv_pkg;

    // Width of every sample and result field on the ports
    localparam int SAMPLE_W = 16;

    // Coefficients carry 10 fractional bits; add half an LSB before the shift
    localparam int FRAC_BITS = 10;
    localparam int ROUND_ADD = 1 << (FRAC_BITS - 1);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_ROW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_U_ROW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_V_ROW = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_sample;
        logic [SAMPLE_W-1:0] green_sample;
        logic [SAMPLE_W-1:0] blue_sample;
    } rgb_pixel_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma_out;
        logic [SAMPLE_W-1:0] cb_out;
        logic [SAMPLE_W-1:0] cr_out;
    } yuv_pixel_t;

endpackage

[rtl/rgbyuv_row.sv]
`timescale 1ns / 1ps

// One matrix row: register the three products, then sum, round, shift,
// offset and clamp into the result register.
module rgbyuv_row
    import rgbyuv_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int COEFF_BITS  = 11,
    parameter bit ADD_OFFSET  = 1'b0
)
(
    input  logic                      clk,
    input  logic [SAMPLE_BITS-1:0]    red,
    input  logic [SAMPLE_BITS-1:0]    green,
    input  logic [SAMPLE_BITS-1:0]    blue,
    input  logic [3*COEFF_BITS-1:0]   coeffs,
    output logic [SAMPLE_W-1:0]       code
);

    localparam int PROD_W  = SAMPLE_BITS + COEFF_BITS + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHR_W   = SUM_W - FRAC_BITS;
    localparam int CODE_W  = SHR_W + 1;
    localparam int ALIGN_W = SAMPLE_W - SAMPLE_BITS;

    localparam logic signed [CODE_W-1:0] CHROMA_OFFSET =
        ADD_OFFSET ? CODE_W'(1 << (SAMPLE_BITS - 1)) : '0;
    localparam logic signed [CODE_W-1:0] CODE_MAX = CODE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic signed [SUM_W-1:0]  ROUND_TERM = SUM_W'(ROUND_ADD);

    logic signed [SAMPLE_BITS:0]   s_red, s_green, s_blue;
    logic signed [COEFF_BITS-1:0]  c_red, c_green, c_blue;
    logic signed [PROD_W-1:0]      prod_r_next, prod_g_next, prod_b_next;
    logic signed [PROD_W-1:0]      prod_r_reg, prod_g_reg, prod_b_reg;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SHR_W-1:0]       shifted;
    logic signed [CODE_W-1:0]      level;
    logic [SAMPLE_BITS-1:0]        clamped;
    logic [SAMPLE_W-1:0]           code_next, code_reg;

    // Products: samples are unsigned, so widen with a zero sign bit
    always_comb
    begin
        s_red   = $signed({1'b0, red});
        s_green = $signed({1'b0, green});
        s_blue  = $signed({1'b0, blue});
        c_red   = $signed(coeffs[COEFF_BITS-1:0]);
        c_green = $signed(coeffs[2*COEFF_BITS-1:COEFF_BITS]);
        c_blue  = $signed(coeffs[3*COEFF_BITS-1:2*COEFF_BITS]);
        prod_r_next = PROD_W'(s_red)   * PROD_W'(c_red);
        prod_g_next = PROD_W'(s_green) * PROD_W'(c_green);
        prod_b_next = PROD_W'(s_blue)  * PROD_W'(c_blue);
    end

    always_ff @(posedge clk)
    begin
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        prod_b_reg <= prod_b_next;
    end

    // Dropping the fraction bits of a two's complement sum floors it
    always_comb
    begin
        sum = SUM_W'(prod_r_reg) + SUM_W'(prod_g_reg) + SUM_W'(prod_b_reg) + ROUND_TERM;
        shifted = $signed(sum[SUM_W-1:FRAC_BITS]);
        level = CODE_W'(shifted) + CHROMA_OFFSET;
        if (level[CODE_W-1])
        begin
            clamped = '0;
        end
        else if (level > CODE_MAX)
        begin
            clamped = CODE_MAX[SAMPLE_BITS-1:0];
        end
        else
        begin
            clamped = level[SAMPLE_BITS-1:0];
        end
        code_next = {clamped, {ALIGN_W{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

[rtl/rgb_to_yuv_matrix_convert.sv]
`timescale 1ns / 1ps
// An accepted request passes the input register, product register and result register;
// its result shows, with done high, for one cycle.
// Throughput: one pixel per clock; busy stays low, so start may be held every cycle.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset (rst_n low, asynchronous) clears the pipeline valids and all coefficients to 0.
module rgb_to_yuv_matrix_convert
    import rgbyuv_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int COEFF_BITS  = 11
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Pixel request
    input  logic                      start,
    output logic                      busy,
    input  rgb_pixel_t                pixel,
    // Converted pixel
    output logic                      done,
    output yuv_pixel_t                result,
    // Coefficient write port
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [3*COEFF_BITS-1:0]   cfg_data
);

    localparam int ROW_W   = 3 * COEFF_BITS;
    localparam int ALIGN_W = SAMPLE_W - SAMPLE_BITS;

    logic                   accept;
    logic                   s1_valid_reg, s2_valid_reg, done_reg;
    logic [SAMPLE_BITS-1:0] red_reg, green_reg, blue_reg;
    logic [ROW_W-1:0]       y_row_reg, u_row_reg, v_row_reg;
    logic [SAMPLE_W-1:0]    luma_code, cb_code, cr_code;

    // Every stage moves every cycle, so no request is ever refused
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Coefficient registers; writes to an unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_row_reg <= '0;
            u_row_reg <= '0;
            v_row_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_Y_ROW: y_row_reg <= cfg_data;
                CFG_U_ROW: u_row_reg <= cfg_data;
                CFG_V_ROW: v_row_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Valid pipeline: input register, product register, result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    // Input register: keep only the significant top bits of each sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= pixel.red_sample[SAMPLE_W-1 -: SAMPLE_BITS];
            green_reg <= pixel.green_sample[SAMPLE_W-1 -: SAMPLE_BITS];
            blue_reg  <= pixel.blue_sample[SAMPLE_W-1 -: SAMPLE_BITS];
        end
    end

    // Luma row has no offset; both chroma rows are centered at mid-scale
    rgbyuv_row #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS),
        .ADD_OFFSET  (1'b0)
    ) u_row_y (
        .clk    (clk),
        .red    (red_reg),
        .green  (green_reg),
        .blue   (blue_reg),
        .coeffs (y_row_reg),
        .code   (luma_code)
    );

    rgbyuv_row #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS),
        .ADD_OFFSET  (1'b1)
    ) u_row_u (
        .clk    (clk),
        .red    (red_reg),
        .green  (green_reg),
        .blue   (blue_reg),
        .coeffs (u_row_reg),
        .code   (cb_code)
    );

    rgbyuv_row #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS),
        .ADD_OFFSET  (1'b1)
    ) u_row_v (
        .clk    (clk),
        .red    (red_reg),
        .green  (green_reg),
        .blue   (blue_reg),
        .coeffs (v_row_reg),
        .code   (cr_code)
    );

    assign done            = done_reg;
    assign result.luma_out = luma_code;
    assign result.cb_out   = cb_code;
    assign result.cr_out   = cr_code;

    // Every accepted request comes out with done through the input, product and result registers
    a_request_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##2 done)
        else $error("accepted request produced no result");

    // No result without a matching earlier request
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a matching request");

    // Results are MSB aligned: the bits below the code stay clear
    a_result_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.luma_out[ALIGN_W-1:0] == '0) && (result.cb_out[ALIGN_W-1:0] == '0)
                 && (result.cr_out[ALIGN_W-1:0] == '0))
        else $error("result low bits not clear");

endmodule

[test/rgb_to_yuv_matrix_convert_tb.sv]
`timescale 1ns / 1ps

module rgb_to_yuv_matrix_convert_tb;
    import rgbyuv_pkg::*;

    localparam int SAMPLE_BITS = 10;
    localparam int COEFF_BITS  = 11;
    localparam int ROW_W       = 3 * COEFF_BITS;
    localparam int ALIGN_SHIFT = SAMPLE_BITS == 10 ? SAMPLE_W - SAMPLE_BITS : 6;
    localparam longint CODE_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam longint CHROMA_OFFSET = 1 << (SAMPLE_BITS - 1);

    // The write port decodes two index bits; the fourth code selects nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    // Pipeline has input, product and result registers; leave some margin before touching the coefficients
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 165;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    rgb_pixel_t             pixel = '0;
    logic                   done;
    yuv_pixel_t             result;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_Y_ROW;
    logic [ROW_W-1:0]       cfg_data = '0;

    // Local copy of the three coefficient rows, as the block should hold them
    logic [ROW_W-1:0] y_coeffs = '0;
    logic [ROW_W-1:0] u_coeffs = '0;
    logic [ROW_W-1:0] v_coeffs = '0;

    rgb_pixel_t rgb_backlog[$];
    yuv_pixel_t pending_yuv[$];

    int send_idle_pct   = 7;
    int fail_count      = 0;
    int pixels_sent     = 0;
    int pixels_checked  = 0;
    int matrices_loaded = 0;
    int quiet_cycles    = 0;

    rgb_to_yuv_matrix_convert #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Conversion predictor
    // ------------------------------------------------------------------

    // One matrix row: signed dot product plus half an LSB, floored by the shift
    function automatic longint row_dot(logic [ROW_W-1:0] coeffs, logic [SAMPLE_BITS-1:0] r,
                                       logic [SAMPLE_BITS-1:0] g, logic [SAMPLE_BITS-1:0] b);
        logic signed [COEFF_BITS-1:0] kr;
        logic signed [COEFF_BITS-1:0] kg;
        logic signed [COEFF_BITS-1:0] kb;
        longint acc;
        kr = coeffs[COEFF_BITS-1:0];
        kg = coeffs[2*COEFF_BITS-1:COEFF_BITS];
        kb = coeffs[3*COEFF_BITS-1:2*COEFF_BITS];
        acc = longint'(r) * longint'(kr) + longint'(g) * longint'(kg)
            + longint'(b) * longint'(kb) + ROUND_ADD;
        // Arithmetic shift on a signed longint rounds toward minus infinity
        return acc >>> FRAC_BITS;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_align(longint code);
        logic [SAMPLE_BITS-1:0] clipped;
        if (code < 0)
            clipped = '0;
        else if (code > CODE_MAX)
            clipped = CODE_MAX[SAMPLE_BITS-1:0];
        else
            clipped = code[SAMPLE_BITS-1:0];
        return {clipped, {ALIGN_SHIFT{1'b0}}};
    endfunction

    function automatic yuv_pixel_t convert_pixel(rgb_pixel_t px);
        logic [SAMPLE_BITS-1:0] r;
        logic [SAMPLE_BITS-1:0] g;
        logic [SAMPLE_BITS-1:0] b;
        yuv_pixel_t yuv;
        // Only the top sample bits count; the rest are dropped
        r = px.red_sample[SAMPLE_W-1:ALIGN_SHIFT];
        g = px.green_sample[SAMPLE_W-1:ALIGN_SHIFT];
        b = px.blue_sample[SAMPLE_W-1:ALIGN_SHIFT];
        yuv.luma_out = clamp_align(row_dot(y_coeffs, r, g, b));
        yuv.cb_out   = clamp_align(row_dot(u_coeffs, r, g, b) + CHROMA_OFFSET);
        yuv.cr_out   = clamp_align(row_dot(v_coeffs, r, g, b) + CHROMA_OFFSET);
        return yuv;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pull from the backlog, hold start across back-to-back pixels
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            pixel <= '0;
        end
        else begin
            // Record the request the block took at this edge
            if (start && !busy) begin
                pending_yuv = {pending_yuv, convert_pixel(pixel)};
                pixels_sent++;
            end
            if (start && busy) begin
                // Hold the request until the block takes it
            end
            else if (rgb_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                start <= 1'b1;
                pixel <= rgb_backlog.pop_front();
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every strobe must match the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        yuv_pixel_t want;
        if (rst_n && done) begin
            if (pending_yuv.size() == 0) begin
                $error("unexpected result: luma_out %h cb_out %h cr_out %h",
                       result.luma_out, result.cb_out, result.cr_out);
                fail_count++;
            end
            else begin
                want = pending_yuv.pop_front();
                pixels_checked++;
                if (result.luma_out !== want.luma_out) begin
                    $error("luma_out: expected %h, got %h", want.luma_out, result.luma_out);
                    fail_count++;
                end
                if (result.cb_out !== want.cb_out) begin
                    $error("cb_out: expected %h, got %h", want.cb_out, result.cb_out);
                    fail_count++;
                end
                if (result.cr_out !== want.cr_out) begin
                    $error("cr_out: expected %h, got %h", want.cr_out, result.cr_out);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: abort when nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_yuv.size());
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [ROW_W-1:0] pack_row(int kr, int kg, int kb);
        return {kb[COEFF_BITS-1:0], kg[COEFF_BITS-1:0], kr[COEFF_BITS-1:0]};
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        // Push some samples to the rails so clamps and saturation show up often
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
        endcase
    endfunction

    task automatic queue_random(int count);
        rgb_pixel_t px;
        repeat (count) begin
            px.red_sample   = random_sample();
            px.green_sample = random_sample();
            px.blue_sample  = random_sample();
            rgb_backlog = {rgb_backlog, px};
        end
    endtask

    task automatic queue_pixel(logic [SAMPLE_W-1:0] r, logic [SAMPLE_W-1:0] g,
                               logic [SAMPLE_W-1:0] b);
        rgb_pixel_t px;
        px.red_sample   = r;
        px.green_sample = g;
        px.blue_sample  = b;
        rgb_backlog = {rgb_backlog, px};
    endtask

    // Drain all requests and results, then let the pipeline settle
    task automatic wait_idle();
        while (rgb_backlog.size() != 0 || start)
            @(posedge clk);
        while (pending_yuv.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_coeffs(logic [CFG_INDEX_W-1:0] index, logic [ROW_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        // Mirror the write; the spare index must leave every row alone
        case (index)
            CFG_Y_ROW: y_coeffs = value;
            CFG_U_ROW: u_coeffs = value;
            CFG_V_ROW: v_coeffs = value;
            default:   ;
        endcase
    endtask

    task automatic load_matrix(logic [ROW_W-1:0] y_row, logic [ROW_W-1:0] u_row,
                               logic [ROW_W-1:0] v_row);
        write_coeffs(CFG_Y_ROW, y_row);
        write_coeffs(CFG_U_ROW, u_row);
        write_coeffs(CFG_V_ROW, v_row);
        matrices_loaded++;
    endtask

    function automatic logic [ROW_W-1:0] random_row();
        return {1'($urandom_range(0, 1)), $urandom()};
    endfunction

    // Full-range BT.601-style matrix with some jitter so sums stay mostly in range
    function automatic logic [ROW_W-1:0] jitter_row(int kr, int kg, int kb);
        return pack_row(kr + $urandom_range(0, 200) - 100, kg + $urandom_range(0, 200) - 100,
                        kb + $urandom_range(0, 200) - 100);
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coefficients out of reset are all zero: Y at 0, chroma at mid-scale
        send_idle_pct = 7;
        queue_pixel('0, '0, '0);
        queue_pixel('1, '1, '1);
        queue_random(RANDOM_ITEMS);
        wait_idle();

        // Standard matrix with directed corner pixels
        load_matrix(pack_row(306, 601, 117), pack_row(-173, -339, 512),
                    pack_row(512, -429, -83));
        queue_pixel(16'h0000, 16'h0000, 16'h0000);
        queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_pixel(16'h003F, 16'h003F, 16'h003F);   // only dropped bits set
        queue_pixel(16'hFFC0, 16'hFFC0, 16'hFFC0);
        queue_pixel(16'h0040, 16'h0040, 16'h0040);   // one code step
        queue_pixel(16'hFFFF, 16'h0000, 16'h0000);
        queue_pixel(16'h0000, 16'hFFFF, 16'h0000);
        queue_pixel(16'h0000, 16'h0000, 16'hFFFF);
        queue_pixel(16'h8000, 16'h8000, 16'h8000);
        queue_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        queue_pixel(16'hAAAA, 16'h5555, 16'h0F0F);
        queue_pixel(16'h5555, 16'hAAAA, 16'hF0F0);
        queue_random(RANDOM_ITEMS - 12);
        wait_idle();

        // Largest positive coefficients: sums run past the top code
        load_matrix(pack_row(1023, 1023, 1023), pack_row(1023, 1023, 1023),
                    pack_row(1023, 1023, 1023));
        queue_random(RANDOM_ITEMS);
        wait_idle();

        // Most negative coefficients: deep negative sums clamp to zero
        send_idle_pct = 55;
        load_matrix(pack_row(-1024, -1024, -1024), pack_row(-1024, -1024, -1024),
                    pack_row(-1024, -1024, -1024));
        queue_random(RANDOM_ITEMS);
        wait_idle();

        // All ones: every coefficient is -1, small negative sums exercise the floor.
        // Follow with a write to the spare index, which must change nothing.
        load_matrix('1, '1, '1);
        write_coeffs(CFG_SPARE, random_row());
        queue_random(RANDOM_ITEMS);
        wait_idle();

        load_matrix(random_row(), random_row(), random_row());
        queue_random(RANDOM_ITEMS);
        wait_idle();

        // No idling from here on: start held high for whole bursts
        send_idle_pct = 0;
        for (phase = 0; phase < 4; phase++) begin
            if (phase[0])
                load_matrix(random_row(), random_row(), random_row());
            else
                load_matrix(jitter_row(306, 601, 117), jitter_row(-173, -339, 512),
                            jitter_row(512, -429, -83));
            write_coeffs(CFG_SPARE, random_row());
            queue_random(RANDOM_ITEMS);
            wait_idle();
        end

        if (pending_yuv.size() != 0) begin
            $error("%0d expected results never arrived", pending_yuv.size());
            fail_count++;
        end

        $display("converted %0d pixels, checked %0d results", pixels_sent, pixels_checked);
        $display("covered reset coefficients and %0d loaded matrices, incl. both extremes",
                 matrices_loaded);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[rgb_to_yuv_matrix_convert.f]
rtl/rgbyuv_pkg.sv
rtl/rgbyuv_row.sv
rtl/rgb_to_yuv_matrix_convert.sv
test/rgb_to_yuv_matrix_convert_tb.sv
